@@ rtl/reno_congestion_window_assert.svh @@
// Assertion macros used by the congestion window datapath.
`ifndef RENO_CONGESTION_WINDOW_ASSERT_SVH
`define RENO_CONGESTION_WINDOW_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rcw_pkg.sv @@
// Package with the shared types and constants of the Reno congestion window.
package rcw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_WINDOW = 1024;

  localparam int WIN_W     = 27;
  localparam int SEQ_W     = 32;
  localparam int DUPTHR_W  = 4;
  localparam int DUPCNT_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [WIN_W-1:0] ONE_Q  = WIN_W'(1) << FRAC_BITS;
  localparam logic [WIN_W-1:0] WMAX_Q = WIN_W'(MAX_WINDOW) << FRAC_BITS;

  // Reset values of the configuration registers.
  localparam logic [WIN_W-1:0]    INIT_THRESHOLD_RST = WIN_W'(16) << FRAC_BITS;
  localparam logic [SEQ_W-1:0]    START_SEQ_RST      = '0;
  localparam logic [DUPTHR_W-1:0] DUP_THRESHOLD_RST  = DUPTHR_W'(3);

  // Reciprocal division 2^(2F) / window: one quotient bit per cycle.
  localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int QUO_W     = FRAC_BITS + 1;

  typedef enum logic [1:0] {
    KIND_SENT    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_THRESHOLD = 2'd0,
    CFG_START_SEQ      = 2'd1,
    CFG_DUP_THRESHOLD  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    kind_e             kind;
    logic [SEQ_W-1:0]  ack_number;
    logic              checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_q16;
    logic [WIN_W-1:0] threshold_q16;
    logic             send_allowed;
    logic             retransmit_request;
    logic [SEQ_W-1:0] retransmit_seq;
    logic             recovering;
    logic [SEQ_W-1:0] window_base;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic classify;
    logic div_start;
    logic update;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/reno_congestion_window.sv @@
// Top level of the Reno congestion window block: controller, datapath and divider.
//
// This block keeps the sender-side Reno congestion window (Q16 fixed point) and a sliding
// send window. Each input item is one event: a packet sent, an acknowledgement received,
// or a retransmit timeout. Every item yields exactly one result item that carries the
// window, slow-start threshold, send permission, fast-retransmit request and window base
// after the event. Items are handled one at a time. After acceptance an item passes through
// the classify, update and emit states; an ack in congestion avoidance also passes through
// the divide state between classify and update, because the growth term 2^32 / window is
// formed by a bit-serial restoring divider that produces one quotient bit per cycle. The
// emit state waits while the output register holds a result that has not been taken. The
// result then sits in an output register, so the next item is accepted while a finished
// result still waits to be taken. Configuration writes are taken only while no item is
// in progress; writing the initial threshold also loads the threshold, and writing the
// start sequence also resets the window base and next sequence number.
module reno_congestion_window (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rcw_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rcw_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rcw_pkg::CFG_DAT_W-1:0]   cfg_data_i
);
  import rcw_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       cfg_we;

  // A configuration write lands when the controller reports no item in flight.
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  rcw_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds all window state and the output register.
  rcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/rcw_divider.sv @@
// Bit-serial restoring divider that forms 2^(2*FRAC_BITS) / divisor.
module rcw_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rcw_pkg::WIN_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [rcw_pkg::QUO_W-1:0] quotient_o
);
  import rcw_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WIN_W-1:0]     rem_q, rem_d;
  logic [QUO_W-1:0]     quo_q, quo_d;

  logic             bit_in;
  logic [WIN_W:0]   rem_sh;
  logic [WIN_W:0]   diff;
  logic             fits;

  // The dividend is a single one at bit 2F, so only the first step shifts in a one.
  assign bit_in = (cnt_q == DIV_CNT_W'(2 * FRAC_BITS));
  assign rem_sh = {rem_q, bit_in};
  assign diff   = rem_sh - {1'b0, divisor_i};
  assign fits   = (rem_sh >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/rcw_controller.sv @@
// Sequencing state machine of the congestion window block.
module rcw_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                cfg_ready_o,
  input  rcw_pkg::dp_status_t status_i,
  output rcw_pkg::ctl_cmd_t   cmd_o
);
  import rcw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_DIVIDE,
    S_UPDATE,
    S_EMIT
  } ctl_state_e;

  ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_CLASSIFY;
      S_CLASSIFY: state_d = status_i.need_div ? S_DIVIDE : S_UPDATE;
      S_DIVIDE:   if (status_i.div_done) state_d = S_UPDATE;
      S_UPDATE:   state_d = S_EMIT;
      S_EMIT:     if (status_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.classify  = (state_q == S_CLASSIFY);
  assign cmd_o.div_start = (state_q == S_CLASSIFY) && status_i.need_div;
  assign cmd_o.update    = (state_q == S_UPDATE);
  assign cmd_o.emit      = (state_q == S_EMIT) && status_i.out_free;

endmodule

@@ rtl/rcw_datapath.sv @@
// Window state, ack classification, update arithmetic and output register.
`include "reno_congestion_window_assert.svh"
module rcw_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rcw_pkg::ctl_cmd_t           cmd_i,
  output rcw_pkg::dp_status_t         status_o,
  input  rcw_pkg::in_item_t           in_data_i,
  input  logic                        cfg_we_i,
  input  logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rcw_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rcw_pkg::out_item_t          out_data_o
);
  import rcw_pkg::*;

  function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                               input logic [WIN_W-1:0] b);
    logic [WIN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, WMAX_Q}) ? WMAX_Q : s[WIN_W-1:0];
  endfunction

  function automatic logic [WIN_W-1:0] halved(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] h;
    h = w >> 1;
    return (h < ONE_Q) ? ONE_Q : h;
  endfunction

  function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    r = v;
    if (v < ONE_Q) r = ONE_Q;
    else if (v > WMAX_Q) r = WMAX_Q;
    return r;
  endfunction

  // Window state.
  logic [WIN_W-1:0]    window_q, window_d;
  logic [WIN_W-1:0]    thr_q, thr_d;
  logic [DUPCNT_W-1:0] dup_cnt_q, dup_cnt_d;
  logic                rec_q, rec_d;
  logic [SEQ_W-1:0]    base_q, base_d;
  logic [SEQ_W-1:0]    next_q, next_d;
  logic [DUPTHR_W-1:0] dup_thr_q, dup_thr_d;
  logic                rtx_q, rtx_d;

  // Item being worked on and its classification.
  in_item_t item_q;
  logic     is_new_q, is_dup_q;

  out_item_t out_q;
  logic      out_valid_q;

  logic [SEQ_W-1:0]    ack_dist;
  logic [SEQ_W-1:0]    outstanding;
  logic                is_new_c;
  logic [WIN_W:0]      win_round;
  logic [SEQ_W-1:0]    packets;
  logic                may_send;
  logic [DUPCNT_W-1:0] cnt_inc;
  logic [WIN_W-1:0]    half_win;
  logic                div_done;
  logic [QUO_W-1:0]    quotient;

  assign ack_dist    = item_q.ack_number - base_q;
  assign outstanding = next_q - base_q;
  assign is_new_c    = (ack_dist != '0) && (ack_dist <= outstanding);

  assign win_round = {1'b0, window_q} + {1'b0, ONE_Q - WIN_W'(1)};
  assign packets   = SEQ_W'(win_round >> FRAC_BITS);
  assign may_send  = (outstanding < packets);

  assign cnt_inc  = (dup_cnt_q != {DUPCNT_W{1'b1}}) ? dup_cnt_q + DUPCNT_W'(1) : dup_cnt_q;
  assign half_win = halved(window_q);

  assign status_o.need_div = (item_q.kind == KIND_ACK) && item_q.checksum_ok && is_new_c &&
                             !rec_q && (window_q >= thr_q);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  rcw_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .divisor_i  (window_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    window_d  = window_q;
    thr_d     = thr_q;
    dup_cnt_d = dup_cnt_q;
    rec_d     = rec_q;
    base_d    = base_q;
    next_d    = next_q;
    dup_thr_d = dup_thr_q;
    rtx_d     = rtx_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INIT_THRESHOLD: thr_d = clamp_win(cfg_data_i[WIN_W-1:0]);
        CFG_START_SEQ: begin
          base_d = cfg_data_i[SEQ_W-1:0];
          next_d = cfg_data_i[SEQ_W-1:0];
        end
        CFG_DUP_THRESHOLD: dup_thr_d = cfg_data_i[DUPTHR_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.update) begin
      rtx_d = 1'b0;
      case (item_q.kind)
        KIND_SENT: begin
          if (may_send) next_d = next_q + SEQ_W'(1);
        end
        KIND_ACK: begin
          if (item_q.checksum_ok) begin
            if (is_new_q) begin
              dup_cnt_d = '0;
              base_d    = item_q.ack_number;
              if (rec_q) begin
                rec_d    = 1'b0;
                window_d = thr_q;
              end else if (window_q < thr_q) begin
                window_d = sat_add(window_q, ONE_Q);
              end else begin
                window_d = sat_add(window_q, WIN_W'(quotient));
              end
            end else if (is_dup_q) begin
              dup_cnt_d = cnt_inc;
              if ((cnt_inc == DUPCNT_W'(dup_thr_q)) && !rec_q) begin
                // Fast retransmit: halve, inflate by the duplicate count, enter recovery.
                rtx_d    = (outstanding != '0);
                thr_d    = half_win;
                window_d = sat_add(half_win, WIN_W'(dup_thr_q) << FRAC_BITS);
                rec_d    = 1'b1;
              end else if ((cnt_inc > DUPCNT_W'(dup_thr_q)) && rec_q) begin
                window_d = sat_add(window_q, ONE_Q);
              end
            end
          end
        end
        KIND_TIMEOUT: begin
          thr_d     = half_win;
          window_d  = ONE_Q;
          dup_cnt_d = '0;
          rec_d     = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= ONE_Q;
      thr_q       <= clamp_win(INIT_THRESHOLD_RST);
      dup_cnt_q   <= '0;
      rec_q       <= 1'b0;
      base_q      <= START_SEQ_RST;
      next_q      <= START_SEQ_RST;
      dup_thr_q   <= DUP_THRESHOLD_RST;
      rtx_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      window_q  <= window_d;
      thr_q     <= thr_d;
      dup_cnt_q <= dup_cnt_d;
      rec_q     <= rec_d;
      base_q    <= base_d;
      next_q    <= next_d;
      dup_thr_q <= dup_thr_d;
      rtx_q     <= rtx_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.classify) begin
      is_new_q <= is_new_c;
      is_dup_q <= (ack_dist == '0);
    end
    if (cmd_i.emit) begin
      out_q.window_q16         <= window_q;
      out_q.threshold_q16      <= thr_q;
      out_q.send_allowed       <= may_send;
      out_q.retransmit_request <= rtx_q;
      out_q.retransmit_seq     <= rtx_q ? base_q : '0;
      out_q.recovering         <= rec_q;
      out_q.window_base        <= base_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RCW_ASSERT_NOW(a_window_range, clk_i, rst_ni, 1'b1, (window_q >= ONE_Q) && (window_q <= WMAX_Q), "window left its range")
  `RCW_ASSERT_NOW(a_thr_range, clk_i, rst_ni, 1'b1, (thr_q >= ONE_Q) && (thr_q <= WMAX_Q), "threshold left its range")
  `RCW_ASSERT_NOW(a_rtx_in_recovery, clk_i, rst_ni, out_valid_q && out_q.retransmit_request, out_q.recovering, "retransmit outside recovery")
  `RCW_ASSERT_NOW(a_quotient_bound, clk_i, rst_ni, div_done, WIN_W'(quotient) <= ONE_Q, "reciprocal above one")
  `RCW_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, cmd_i.emit, out_valid_q, "emitted item not presented")

endmodule

@@ test/reno_congestion_window_tb.sv @@
// Self-checking testbench for the Reno congestion window block, with a built-in window predictor.
`timescale 1ns / 1ps

module reno_congestion_window_tb;
  import rcw_pkg::*;

  // Event code that the block does not define; it must leave the state alone.
  localparam kind_e                KIND_UNUSED = kind_e'(2'd3);
  // Register index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  localparam int unsigned          CYCLE_LIMIT = 1000000;
  localparam int                   DRAIN_CYCLES = 50;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  reno_congestion_window dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the sender state, advanced once per accepted item.
  logic [WIN_W-1:0]    cwnd;
  logic [WIN_W-1:0]    ssthresh;
  logic [DUPCNT_W-1:0] dup_acks;
  bit                  in_recovery;
  logic [SEQ_W-1:0]    snd_una;
  logic [SEQ_W-1:0]    snd_nxt;

  // Shadow copy of the configuration registers.
  logic [WIN_W-1:0]    cfg_init_ssthresh;
  logic [SEQ_W-1:0]    cfg_isn;
  logic [DUPTHR_W-1:0] cfg_dupthresh;

  // Window reports the block still owes us, oldest first.
  out_item_t window_reports[$];

  int unsigned mismatches = 0;
  bit          idle_en = 1'b1;   // random gaps on both sides
  int          hold_left = 0;    // long receiver hold-off, in cycles
  int          stall_left = 0;

  function automatic logic [WIN_W-1:0] clamp_q16(logic [WIN_W-1:0] v);
    if (v < ONE_Q) return ONE_Q;
    if (v > WMAX_Q) return WMAX_Q;
    return v;
  endfunction

  // Saturating window growth; the sum of two window values fits in 32 bits.
  function automatic logic [WIN_W-1:0] cap_window(logic [31:0] sum);
    return (sum > 32'(WMAX_Q)) ? WMAX_Q : sum[WIN_W-1:0];
  endfunction

  function automatic logic [WIN_W-1:0] halve_cwnd(logic [WIN_W-1:0] w);
    return ((w >> 1) < ONE_Q) ? ONE_Q : (w >> 1);
  endfunction

  // Another packet may go out while the flight size is below the window in whole packets.
  function automatic bit send_window_open();
    logic [SEQ_W-1:0] in_flight;
    logic [31:0]      packets;
    in_flight = snd_nxt - snd_una;
    packets = (32'(cwnd) + 32'(ONE_Q) - 32'd1) >> FRAC_BITS;
    return in_flight < packets;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_INIT_THRESHOLD: begin
        cfg_init_ssthresh = data[WIN_W-1:0];
        ssthresh = clamp_q16(cfg_init_ssthresh);
      end
      CFG_START_SEQ: begin
        cfg_isn = data[SEQ_W-1:0];
        snd_una = cfg_isn;
        snd_nxt = cfg_isn;
      end
      CFG_DUP_THRESHOLD: cfg_dupthresh = data[DUPTHR_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the shadow state by one event and queue the window report it must produce.
  function automatic void step_reno(in_item_t evt);
    logic [SEQ_W-1:0] delta;
    logic [SEQ_W-1:0] in_flight;
    logic [63:0]      growth;
    bit               fast_rtx;
    out_item_t        rpt;
    fast_rtx = 1'b0;
    case (evt.kind)
      KIND_SENT: begin
        if (send_window_open()) snd_nxt = snd_nxt + 1;
      end
      KIND_ACK: begin
        if (evt.checksum_ok) begin
          delta = evt.ack_number - snd_una;
          in_flight = snd_nxt - snd_una;
          if (delta != 0 && delta <= in_flight) begin
            // New data acknowledged.
            dup_acks = '0;
            if (in_recovery) begin
              in_recovery = 1'b0;
              cwnd = ssthresh;
            end else if (cwnd < ssthresh) begin
              cwnd = cap_window(32'(cwnd) + 32'(ONE_Q));
            end else begin
              growth = (64'd1 << (2 * FRAC_BITS)) / 64'(cwnd);
              cwnd = cap_window(32'(cwnd) + growth[31:0]);
            end
            snd_una = evt.ack_number;
          end else if (delta == 0) begin
            if (dup_acks != '1) dup_acks = dup_acks + 1;
            if (dup_acks == DUPCNT_W'(cfg_dupthresh) && !in_recovery) begin
              fast_rtx = (in_flight != 0);
              ssthresh = halve_cwnd(cwnd);
              cwnd = cap_window(32'(ssthresh) + (32'(cfg_dupthresh) << FRAC_BITS));
              in_recovery = 1'b1;
            end else if (dup_acks > DUPCNT_W'(cfg_dupthresh) && in_recovery) begin
              cwnd = cap_window(32'(cwnd) + 32'(ONE_Q));
            end
          end
        end
      end
      KIND_TIMEOUT: begin
        ssthresh = halve_cwnd(cwnd);
        cwnd = ONE_Q;
        dup_acks = '0;
        in_recovery = 1'b0;
      end
      default: ;
    endcase
    rpt.window_q16 = cwnd;
    rpt.threshold_q16 = ssthresh;
    rpt.send_allowed = send_window_open();
    rpt.retransmit_request = fast_rtx;
    rpt.retransmit_seq = fast_rtx ? snd_una : '0;
    rpt.recovering = in_recovery;
    rpt.window_base = snd_una;
    window_reports.push_back(rpt);
  endfunction

  task automatic flag_error(string what);
    if (mismatches < 40) $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Offer one item, hold it until the block takes it, then predict its report.
  // Valid is only lowered ahead of a gap, so it is never dropped and raised in one step.
  task automatic send_item(kind_e k, logic [SEQ_W-1:0] ack, logic csum_ok);
    in_item_t evt;
    int       gap;
    evt.kind = k;
    evt.ack_number = ack;
    evt.checksum_ok = csum_ok;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= evt;
    do @(posedge clk_i); while (in_stall_o);
    step_reno(evt);
  endtask

  // Stop offering items and wait until every report has come back.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (window_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
  endtask

  // Registers are only written with the block idle; valid stays up across the writes.
  task automatic configure(logic [WIN_W-1:0] init_thr, logic [SEQ_W-1:0] isn,
                           logic [DUPTHR_W-1:0] dupthresh, bit poke_unused);
    wait_quiet();
    if (poke_unused) write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_INIT_THRESHOLD, CFG_DAT_W'(init_thr));
    write_reg(CFG_START_SEQ, isn);
    write_reg(CFG_DUP_THRESHOLD, CFG_DAT_W'(dupthresh));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: sends, acks of data in flight, bursts of duplicates
  // long enough to reach fast retransmit and inflation, the odd timeout, and some noise.
  task automatic send_traffic(int count);
    int               sent;
    int               pick;
    int               burst;
    logic [SEQ_W-1:0] in_flight;
    sent = 0;
    while (sent < count) begin
      in_flight = snd_nxt - snd_una;
      pick = $urandom_range(0, 99);
      if (pick < 30 || (pick < 60 && in_flight == 0)) begin
        send_item(KIND_SENT, $urandom, 1'($urandom));
        sent++;
      end else if (pick < 60) begin
        // Usually one packet at a time, sometimes a cumulative jump.
        send_item(KIND_ACK, snd_una + (($urandom_range(0, 3) == 0) ?
                  $urandom_range(1, in_flight) : 1), 1'b1);
        sent++;
      end else if (pick < 72) begin
        burst = $urandom_range(1, int'(cfg_dupthresh) + 3);
        repeat (burst) send_item(KIND_ACK, snd_una, 1'b1);
        sent += burst;
      end else if (pick < 76) begin
        send_item(KIND_TIMEOUT, $urandom, 1'($urandom));
        sent++;
      end else begin
        // Mostly noise that the block should ignore; it does not count toward the total.
        case ($urandom_range(0, 3))
          0: send_item(KIND_ACK, $urandom, 1'b0);
          1: send_item(KIND_ACK, $urandom, 1'b1);
          2: send_item(KIND_ACK, snd_nxt + $urandom_range(1, 8), 1'b1);
          default: send_item(KIND_UNUSED, $urandom, 1'($urandom));
        endcase
      end
    end
  endtask

  // Hand-picked events on the reset configuration (threshold 16, three duplicates, sequence 0).
  task automatic test_directed_events();
    send_item(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_SENT, 32'h0, 1'b0);
    // The one-packet window is full, so this send must be refused.
    send_item(KIND_SENT, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_ACK, 32'd1, 1'b0);
    send_item(KIND_ACK, 32'd5, 1'b1);
    send_item(KIND_ACK, 32'd1, 1'b1);
    repeat (3) send_item(KIND_SENT, 32'h0, 1'b1);
    // Three duplicates: fast retransmit of sequence 1, then window inflation.
    repeat (5) send_item(KIND_ACK, 32'd1, 1'b1);
    // A new ack leaves recovery and the window falls back to the threshold.
    send_item(KIND_ACK, 32'd3, 1'b1);
    send_item(KIND_SENT, 32'h0, 1'b1);
    // Window equals threshold here, so this ack goes through the divider.
    send_item(KIND_ACK, 32'd4, 1'b1);
    send_item(KIND_ACK, 32'd2, 1'b1);
    // Fast retransmit with nothing in flight enters recovery without a request.
    repeat (3) send_item(KIND_ACK, 32'd4, 1'b1);
    send_item(KIND_TIMEOUT, 32'h0, 1'b0);
    send_item(KIND_ACK, 32'h0, 1'b0);
    send_item(KIND_SENT, 32'h0, 1'b1);
    send_item(KIND_ACK, 32'd5, 1'b1);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the block
  // fills its result register and must stall the sender.
  task automatic test_output_backpressure();
    idle_en = 1'b0;
    hold_left = 400;
    send_traffic(24);
    idle_en = 1'b1;
  endtask

  task automatic test_register_extremes();
    // Threshold below one packet clamps up, the sequence space wraps, and zero
    // duplicates means fast retransmit can never fire.
    configure('0, 32'hFFFF_FFF0, '0, 1'b1);
    send_traffic(120);
    // Largest threshold clamps to the maximum window; most duplicates allowed.
    configure('1, 32'hFFFF_FFFF, '1, 1'b0);
    send_traffic(120);
    // Threshold of one packet puts new acks into congestion avoidance from the start.
    configure(ONE_Q, 32'h0, DUPTHR_W'(1), 1'b0);
    send_traffic(100);
  endtask

  task automatic test_random_traffic();
    repeat (2) begin
      configure(WIN_W'($urandom_range(32'(ONE_Q), 48 << FRAC_BITS)), $urandom,
                DUPTHR_W'($urandom_range(0, 15)), 1'($urandom));
      send_traffic(120);
    end
  endtask

  // Drive the window to its ceiling through a long run of duplicates in recovery,
  // which also pins the duplicate counter at its limit, then halve the full window.
  task automatic test_window_saturation();
    configure('1, $urandom, DUPTHR_W'(15), 1'b0);
    send_item(KIND_TIMEOUT, $urandom, 1'b1);
    send_item(KIND_SENT, $urandom, 1'b1);
    while (cwnd != WMAX_Q) begin
      if ($urandom_range(0, 9) == 0) send_item(KIND_SENT, $urandom, 1'($urandom));
      else send_item(KIND_ACK, snd_una, 1'b1);
    end
    repeat (10) send_item(KIND_ACK, snd_una, 1'b1);
    send_item(KIND_TIMEOUT, $urandom, 1'b1);
    send_traffic(60);
  endtask

  // Last stretch runs without any gaps on either side.
  task automatic test_steady_stream();
    configure(WIN_W'($urandom_range(32'(ONE_Q), 24 << FRAC_BITS)), $urandom,
              DUPTHR_W'($urandom_range(1, 6)), 1'b0);
    idle_en = 1'b0;
    send_traffic(120);
  endtask

  // Every accepted report is checked field by field against the oldest prediction.
  always @(posedge clk_i) begin : report_checker
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (window_reports.size() == 0) begin
        flag_error("report arrived with no event pending");
      end else begin
        want = window_reports.pop_front();
        if (out_data_o.window_q16 !== want.window_q16)
          flag_error($sformatf("window_q16 %h, expected %h",
                               out_data_o.window_q16, want.window_q16));
        if (out_data_o.threshold_q16 !== want.threshold_q16)
          flag_error($sformatf("threshold_q16 %h, expected %h",
                               out_data_o.threshold_q16, want.threshold_q16));
        if (out_data_o.send_allowed !== want.send_allowed)
          flag_error($sformatf("send_allowed %b, expected %b",
                               out_data_o.send_allowed, want.send_allowed));
        if (out_data_o.retransmit_request !== want.retransmit_request)
          flag_error($sformatf("retransmit_request %b, expected %b",
                               out_data_o.retransmit_request, want.retransmit_request));
        if (out_data_o.retransmit_seq !== want.retransmit_seq)
          flag_error($sformatf("retransmit_seq %h, expected %h",
                               out_data_o.retransmit_seq, want.retransmit_seq));
        if (out_data_o.recovering !== want.recovering)
          flag_error($sformatf("recovering %b, expected %b",
                               out_data_o.recovering, want.recovering));
        if (out_data_o.window_base !== want.window_base)
          flag_error($sformatf("window_base %h, expected %h",
                               out_data_o.window_base, want.window_base));
      end
    end
  end

  // Receiver side: a long hold-off when asked for, otherwise random stall bursts.
  always @(posedge clk_i) begin : report_receiver
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    // Shadow state matches the block's reset values.
    cfg_init_ssthresh = INIT_THRESHOLD_RST;
    cfg_isn = START_SEQ_RST;
    cfg_dupthresh = DUP_THRESHOLD_RST;
    cwnd = ONE_Q;
    ssthresh = clamp_q16(cfg_init_ssthresh);
    dup_acks = '0;
    in_recovery = 1'b0;
    snd_una = cfg_isn;
    snd_nxt = cfg_isn;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_events();
    test_output_backpressure();
    test_register_extremes();
    test_random_traffic();
    test_window_saturation();
    test_steady_stream();

    // Let any stray report show up before the verdict.
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
